[hw/rtl/assert_macros.svh]
// assertion macros shared by the console engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define TCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication under synchronous active-low reset
`define TCCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[hw/rtl/tcce_pkg.sv]
// shared types and constants of the text console character engine
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int OPCODE_W    = 2;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int COL_OUT_W   = 7;
    localparam int ROW_OUT_W   = 5;
    localparam int CELL_W      = 16;
    localparam int COLOR_W     = 4;
    localparam int ATTR_W      = 2 * COLOR_W;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR = 2'd0,
        CFG_BG_COLOR = 2'd1
    } t_cfg_reg;

    localparam logic [CHAR_W-1:0]  CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0]  CH_HT    = 8'h09;
    localparam logic [CHAR_W-1:0]  CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0]  CH_SPACE = 8'h20;

    localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;
    localparam logic [CELL_W-1:0]  RESET_CELL = 16'h0720;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic init_step;
        logic blank_step;
        logic copy_step;
        logic copy_tail;
        logic read_capture;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic addr_last;
        logic to_scroll;
        logic to_clear;
        logic to_read;
    } t_dp_stat;

endpackage

[hw/rtl/tcce_intf.sv]
// request, result and configuration channel interfaces
`timescale 1ns / 1ps

interface tcce_in_if;
    import tcce_pkg::*;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;

    modport source (output valid, opcode, char_code, cell_index, input ready);
    modport sink   (input valid, opcode, char_code, cell_index, output ready);
endinterface

interface tcce_res_if;
    import tcce_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [CELL_W-1:0]    cell_value;
    logic                 scrolled;

    modport source (output valid, cursor_col, cursor_row, cell_value, scrolled, input ready);
    modport sink   (input valid, cursor_col, cursor_row, cell_value, scrolled, output ready);
endinterface

interface tcce_cfg_if;
    import tcce_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tcce_ctrl.sv]
// controller state machine of the console engine
`timescale 1ns / 1ps

module tcce_ctrl import tcce_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_COPY_TAIL,
        ST_BLANK,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        case (r_state)
            ST_INIT:      o_cmd.init_step    = 1'b1;
            ST_IDLE:      o_cmd.accept       = i_in_valid;
            ST_READ:      o_cmd.read_capture = 1'b1;
            ST_COPY:      o_cmd.copy_step    = 1'b1;
            ST_COPY_TAIL: o_cmd.copy_tail    = 1'b1;
            ST_BLANK:     o_cmd.blank_step   = 1'b1;
            ST_EMIT:      o_cmd.load_out     = !r_out_valid || i_out_ready;
            default:      o_cmd              = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_INIT: begin
                    if (i_stat.addr_last) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (i_stat.to_read) begin
                            r_state <= ST_READ;
                        end else if (i_stat.to_scroll) begin
                            r_state <= ST_COPY;
                        end else if (i_stat.to_clear) begin
                            r_state <= ST_BLANK;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_READ:      r_state <= ST_EMIT;
                ST_COPY: begin
                    if (i_stat.addr_last) r_state <= ST_COPY_TAIL;
                end
                ST_COPY_TAIL: r_state <= ST_BLANK;
                ST_BLANK: begin
                    if (i_stat.addr_last) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (o_cmd.load_out) r_state <= ST_IDLE;
                end
                default:      r_state <= ST_INIT;
            endcase
        end
    end

endmodule

[hw/rtl/tcce_dp.sv]
// datapath of the console engine: cursor, cell store, sweep counter, result register
`timescale 1ns / 1ps

module tcce_dp import tcce_pkg::*; #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [INDEX_W-1:0]   i_cell_index,
    input  logic [COLOR_W-1:0]   i_fg_color,
    input  logic [COLOR_W-1:0]   i_bg_color,
    output logic [COL_OUT_W-1:0] o_cursor_col,
    output logic [ROW_OUT_W-1:0] o_cursor_row,
    output logic [CELL_W-1:0]    o_cell_value,
    output logic                 o_scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = $clog2(TAB_STOP);
    localparam int CNW   = $clog2(COLUMNS + TAB_STOP) + 1;
    localparam int IXW   = (AW > INDEX_W) ? AW : INDEX_W;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [PW-1:0]     r_phase;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_waddr;
    logic              r_wv;
    logic [CELL_W-1:0] r_cell;
    logic              r_scrolled;

    logic [ATTR_W-1:0] attr;
    logic              is_put;
    logic              printable;
    logic              in_range;
    logic [CNW-1:0]    col_x;
    logic [PW-1:0]     phase_n;
    logic              row_inc;
    logic              put_scroll;
    logic [AW-1:0]     pos;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;

    assign attr      = {i_bg_color, i_fg_color};
    assign is_put    = (i_opcode == OP_PUT);
    assign printable = (i_char_code >= CH_SPACE) && !i_char_code[CHAR_W-1];
    assign in_range  = IXW'(i_cell_index) < IXW'(CELLS);
    assign pos       = AW'(AW'(r_row) * AW'(COLUMNS)) + AW'(r_col);

    // cursor move for one put byte; phase tracks column modulo the tab stop
    always_comb begin
        col_x   = CNW'(r_col);
        phase_n = r_phase;
        row_inc = 1'b0;
        case (i_char_code)
            CH_BS: begin
                if (r_col != '0) begin
                    col_x   = CNW'(r_col) - CNW'(1);
                    phase_n = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
                end
            end
            CH_HT: begin
                col_x   = CNW'(r_col) + CNW'(TAB_STOP) - CNW'(r_phase);
                phase_n = '0;
            end
            CH_CR: begin
                col_x   = '0;
                phase_n = '0;
            end
            CH_LF: begin
                col_x   = '0;
                phase_n = '0;
                row_inc = 1'b1;
            end
            default: begin
                if (printable) begin
                    col_x   = CNW'(r_col) + CNW'(1);
                    phase_n = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
                end
            end
        endcase
        if (col_x >= CNW'(COLUMNS)) begin
            col_x   = '0;
            phase_n = '0;
            row_inc = 1'b1;
        end
        put_scroll = row_inc && (r_row == RW'(ROWS - 1));
    end

    assign o_stat.addr_last = (r_addr == AW'(CELLS - 1));
    assign o_stat.to_scroll = is_put && put_scroll;
    assign o_stat.to_clear  = (i_opcode == OP_CLEAR);
    assign o_stat.to_read   = (i_opcode == OP_READ) && in_range;

    // single write port
    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = RESET_CELL;
        if (i_cmd.init_step) begin
            we = 1'b1;
        end else if (i_cmd.blank_step) begin
            we    = 1'b1;
            wdata = {attr, CH_SPACE};
        end else if ((i_cmd.copy_step && r_wv) || i_cmd.copy_tail) begin
            we    = 1'b1;
            waddr = r_waddr;
            wdata = r_rd_data;
        end else if (i_cmd.accept && is_put && printable) begin
            we    = 1'b1;
            waddr = pos;
            wdata = {attr, i_char_code};
        end
    end

    assign re    = (i_cmd.accept && o_stat.to_read) || i_cmd.copy_step;
    assign raddr = i_cmd.copy_step ? r_addr : AW'(i_cell_index);

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rd_data <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
            r_addr  <= '0;
            r_wv    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (is_put) begin
                    r_col   <= CW'(col_x);
                    r_phase <= phase_n;
                    if (row_inc && !put_scroll) r_row <= r_row + RW'(1);
                end else if (o_stat.to_clear) begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_phase <= '0;
                end
                r_addr <= o_stat.to_clear ? '0 : AW'(COLUMNS);
                r_wv   <= 1'b0;
            end
            if (i_cmd.init_step || i_cmd.blank_step) r_addr <= r_addr + AW'(1);
            if (i_cmd.copy_step) begin
                r_addr <= r_addr + AW'(1);
                r_wv   <= 1'b1;
            end
            if (i_cmd.copy_tail) r_addr <= AW'(CELLS - COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_step) r_waddr <= r_addr - AW'(COLUMNS);
        if (i_cmd.accept) begin
            r_cell     <= '0;
            r_scrolled <= o_stat.to_scroll;
        end
        if (i_cmd.read_capture) r_cell <= r_rd_data;
        if (i_cmd.load_out) begin
            o_cursor_col <= COL_OUT_W'(r_col);
            o_cursor_row <= ROW_OUT_W'(r_row);
            o_cell_value <= r_cell;
            o_scrolled   <= r_scrolled;
        end
    end

endmodule

[hw/rtl/text_console_char_engine.sv]
// top level of the text console character engine
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel  | dir | handshake     | payload
//  i_in     | in  | valid / ready | opcode, char_code, cell_index
//  o_res    | out | valid / ready | cursor_col, cursor_row, cell_value, scrolled
//  i_cfg    | in  | valid / ready | index, data (ready always high)
//
//  per request: a printable put writes its cell; a put that scrolls copies each row
//  up and blanks the last row; a read fetches the cell; a clear blanks all CELLS
//  cells, CELLS = COLUMNS*ROWS; all writes go through the one write port of the store
//  reset: clearing pass writes the blank cell to every cell, i_in.ready stays low
//  results wait in an output register; a new request is taken while one waits
//  and the engine stalls only at the end of the next request until it drains

module text_console_char_engine import tcce_pkg::*; #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcce_in_if.sink    i_in,
    tcce_res_if.source o_res,
    tcce_cfg_if.sink   i_cfg
);

    // color registers, written through the configuration channel
    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color <= FG_RESET;
            r_bg_color <= BG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_FG_COLOR: r_fg_color <= i_cfg.data;
                CFG_BG_COLOR: r_bg_color <= i_cfg.data;
                default:      ;    // writes beyond the register list are dropped
            endcase
        end
    end

    // sequencing: init sweep, request decode, copy and blank sweeps, result hand-off
    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // cursor, cell store and result register
    tcce_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (i_in.opcode),
        .i_char_code  (i_in.char_code),
        .i_cell_index (i_in.cell_index),
        .i_fg_color   (r_fg_color),
        .i_bg_color   (r_bg_color),
        .o_cursor_col (o_res.cursor_col),
        .o_cursor_row (o_res.cursor_row),
        .o_cell_value (o_res.cell_value),
        .o_scrolled   (o_res.scrolled)
    );

    // one request in flight: after an accept the engine is busy and not ready
    `TCCE_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)

    // a scroll leaves the cursor on the bottom row
    `TCCE_ASSERT_IMP(a_scroll_row, i_clk, i_rst_n, o_res.valid && o_res.scrolled,
        o_res.cursor_row == ROW_OUT_W'(ROWS - 1))

    // only a read returns cell data, and a read never scrolls
    `TCCE_ASSERT_IMP(a_scroll_no_cell, i_clk, i_rst_n, o_res.valid && o_res.scrolled,
        o_res.cell_value == '0)

endmodule

[tb/tb_text_console_char_engine.sv]
// self-checking testbench of the text console character engine
`timescale 1ns / 1ps

module tb_text_console_char_engine;
    import tcce_pkg::*;

    // geometry of the screen under test
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    // opcode and register indexes that the package leaves unnamed
    localparam logic [OPCODE_W-1:0]  OP_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [CHAR_W-1:0] CH_LAST_PRINTABLE = 8'h7F;

    // a clear or a scroll takes one pass over the store
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [COL_OUT_W-1:0] cursor_col;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [CELL_W-1:0]    cell_value;
        logic                 scrolled;
    } t_console_result;

    // answer typed into the table, or taken from the predictor
    typedef struct {
        bit              typed;
        t_console_result answer;
    } t_row_answer;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [CHAR_W-1:0]   ch;
        logic [INDEX_W-1:0]  idx;
        bit                  typed;
        t_console_result     answer;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    tcce_in_if  in_if ();
    tcce_res_if res_if ();
    tcce_cfg_if cfg_if ();

    text_console_char_engine #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // predictor state: the screen, the cursor and the two color registers
    logic [CELL_W-1:0]  screen [CELLS];
    int                 cursor_x;
    int                 cursor_y;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;

    // results still owed by the engine, oldest first
    t_console_result expected_results [$];
    // one entry per request driven but not yet accepted
    t_row_answer     table_answers [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    t_stim_row directed_rows [DIRECTED_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // hard stop in case the engine hangs
    initial begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stalls at random, one decision per cycle
    always @(posedge i_clk) res_if.ready <= ($urandom_range(99) >= recv_idle_pct);

    // applies one request to the predictor state and returns the result it causes
    function automatic t_console_result console_apply(input logic [OPCODE_W-1:0] op,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [INDEX_W-1:0] idx);
        t_console_result   res;
        logic [CELL_W-1:0] blank;
        int                pos;
        res   = '0;
        blank = {bg_color, fg_color, CH_SPACE};
        case (op)
            OP_PUT: begin
                if (ch == CH_BS) begin
                    if (cursor_x != 0) cursor_x--;
                end else if (ch == CH_HT) begin
                    cursor_x = (cursor_x / TAB_STOP + 1) * TAB_STOP;
                end else if (ch == CH_CR) begin
                    cursor_x = 0;
                end else if (ch == CH_LF) begin
                    cursor_x = 0;
                    cursor_y++;
                end else if (ch >= CH_SPACE && ch <= CH_LAST_PRINTABLE) begin
                    pos = cursor_y * COLUMNS + cursor_x;
                    screen[pos] = {bg_color, fg_color, ch};
                    cursor_x++;
                end
                // wrap past the last column
                if (cursor_x >= COLUMNS) begin
                    cursor_x = 0;
                    cursor_y++;
                end
                // scroll up one row past the last row
                if (cursor_y >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank;
                    cursor_y     = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen[i] = blank;
                cursor_x = 0;
                cursor_y = 0;
            end
            OP_READ: begin
                if (idx < CELLS) res.cell_value = screen[idx];
            end
            default: begin
            end
        endcase
        res.cursor_col = cursor_x[COL_OUT_W-1:0];
        res.cursor_row = cursor_y[ROW_OUT_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // samples all three channels at the edge, before the engine updates them
    always @(posedge i_clk) begin : monitor
        t_console_result want;
        t_console_result predicted;
        t_row_answer     entry;
        if (i_rst_n) begin
            // register writes go straight into the predictor colors
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_FG_COLOR: fg_color = cfg_if.data;
                    CFG_BG_COLOR: bg_color = cfg_if.data;
                    default: begin
                    end
                endcase
            end
            // a result is matched against the oldest expectation
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h",
                             $time, res_if.cursor_col, res_if.cursor_row,
                             res_if.cell_value, res_if.scrolled);
                end else begin
                    want = expected_results.pop_front();
                    check_field("cursor_col", int'(want.cursor_col), int'(res_if.cursor_col));
                    check_field("cursor_row", int'(want.cursor_row), int'(res_if.cursor_row));
                    check_field("cell_value", int'(want.cell_value), int'(res_if.cell_value));
                    check_field("scrolled", int'(want.scrolled), int'(res_if.scrolled));
                end
            end
            // an accepted request always advances the predictor
            if (in_if.valid && in_if.ready) begin
                predicted = console_apply(in_if.opcode, in_if.char_code, in_if.cell_index);
                if (table_answers.size() != 0) begin
                    entry = table_answers.pop_front();
                    expected_results.push_back(entry.typed ? entry.answer : predicted);
                end else begin
                    expected_results.push_back(predicted);
                end
            end
        end
    end

    // drives one request, with random idle cycles ahead of it, and waits for the handshake
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [INDEX_W-1:0] idx, input bit typed,
                                input t_console_result answer);
        t_row_answer entry;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        entry.typed  = typed;
        entry.answer = answer;
        table_answers.push_back(entry);
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.char_code  <= ch;
        in_if.cell_index <= idx;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    // put with a random, unused cell index
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_request(OP_PUT, ch, INDEX_W'($urandom_range(2047)), 1'b0, '0);
    endtask

    // sender holds off until every result is back, then the engine is idle
    task automatic settle();
        in_if.valid <= 1'b0;
        while (table_answers.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    // writes both colors, optionally also the spare indexes, which must be ignored
    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                              input bit with_spare);
        write_register(CFG_FG_COLOR, fg);
        if (with_spare) write_register(CFG_SPARE_LO, ~fg);
        write_register(CFG_BG_COLOR, bg);
        if (with_spare) write_register(CFG_SPARE_HI, ~bg);
        cfg_if.valid <= 1'b0;
    endtask

    // mostly well-formed text with line ends, tabs and backspaces, plus reads, clears and ignored noise
    task automatic run_random_phase(input int target);
        int sent;
        int kind;
        int n;
        int k;
        logic [CHAR_W-1:0] ctl;
        sent = 0;
        while (sent < target) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                // short line of text, mostly followed by a line end
                n = $urandom_range(12);
                for (k = 0; k < n; k++) put_char(CHAR_W'($urandom_range(127, 32)));
                sent += n;
                case ($urandom_range(3))
                    0, 2: begin
                        put_char(CH_LF);
                        sent++;
                    end
                    1: begin
                        put_char(CH_CR);
                        put_char(CH_LF);
                        sent += 2;
                    end
                    default: begin
                    end
                endcase
            end else if (kind < 40) begin
                // long line that may wrap at the last column
                n = $urandom_range(90, 40);
                for (k = 0; k < n; k++) put_char(CHAR_W'($urandom_range(127, 32)));
                sent += n;
            end else if (kind < 60) begin
                // run of line feeds, each one on the last row scrolls
                n = $urandom_range(8, 1);
                for (k = 0; k < n; k++) put_char(CH_LF);
                sent += n;
            end else if (kind < 68) begin
                // tabs, some interleaved with text, up to and past the last stop
                n = $urandom_range(10, 1);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(3) == 0) begin
                        put_char(CHAR_W'($urandom_range(127, 32)));
                        sent++;
                    end
                    put_char(CH_HT);
                    sent++;
                end
            end else if (kind < 75) begin
                // backspaces, sometimes overwriting what was just put
                n = $urandom_range(5, 1);
                for (k = 0; k < n; k++) begin
                    put_char(CH_BS);
                    sent++;
                    if ($urandom_range(1) == 0) begin
                        put_char(CHAR_W'($urandom_range(127, 32)));
                        sent++;
                    end
                end
            end else if (kind < 88) begin
                // reads, now and then past the end of the store
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++) begin
                    send_request(OP_READ, CHAR_W'($urandom_range(255)),
                                 ($urandom_range(7) == 0)
                                     ? INDEX_W'($urandom_range(2047))
                                     : INDEX_W'($urandom_range(CELLS - 1)),
                                 1'b0, '0);
                end
                sent += n;
            end else if (kind < 95) begin
                // noise that the engine ignores
                case ($urandom_range(2))
                    0: put_char(CHAR_W'($urandom_range(255, 128)));
                    1: begin
                        ctl = CHAR_W'($urandom_range(31));
                        if (ctl == CH_BS || ctl == CH_HT || ctl == CH_LF || ctl == CH_CR)
                            ctl = 8'h00;
                        put_char(ctl);
                    end
                    default: send_request(OP_UNUSED, CHAR_W'($urandom_range(255)),
                                          INDEX_W'($urandom_range(2047)), 1'b0, '0);
                endcase
                sent++;
            end else if (kind < 97) begin
                send_request(OP_CLEAR, CHAR_W'($urandom_range(255)),
                             INDEX_W'($urandom_range(2047)), 1'b0, '0);
                sent++;
            end else begin
                put_char(CH_CR);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        // every input known from time zero
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.opcode     = OP_PUT;
        in_if.char_code  = '0;
        in_if.cell_index = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_FG_COLOR;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;

        // predictor after reset: blank screen, cursor home, default colors
        for (int i = 0; i < CELLS; i++) screen[i] = RESET_CELL;
        cursor_x = 0;
        cursor_y = 0;
        fg_color = FG_RESET;
        bg_color = BG_RESET;

        // directed table: typed answers where they are obvious, predictor elsewhere
        directed_rows = '{
            '{OP_READ,   8'h00,             11'd0,    1'b1, '{7'd0, 5'd0, 16'h0720, 1'b0}},
            '{OP_READ,   8'hFF,             11'd1999, 1'b1, '{7'd0, 5'd0, 16'h0720, 1'b0}},
            '{OP_READ,   8'h00,             11'd2000, 1'b1, '{7'd0, 5'd0, 16'h0000, 1'b0}},
            '{OP_READ,   8'h00,             11'd2047, 1'b1, '{7'd0, 5'd0, 16'h0000, 1'b0}},
            '{OP_UNUSED, 8'hFF,             11'h7FF,  1'b1, '{7'd0, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    CH_BS,             11'd0,    1'b1, '{7'd0, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    8'h41,             11'h7FF,  1'b1, '{7'd1, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    CH_LAST_PRINTABLE, 11'd0,    1'b1, '{7'd2, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    8'h80,             11'd0,    1'b1, '{7'd2, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    8'hFF,             11'h7FF,  1'b1, '{7'd2, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    8'h00,             11'd0,    1'b1, '{7'd2, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    8'h1F,             11'd0,    1'b1, '{7'd2, 5'd0, 16'h0000, 1'b0}},
            '{OP_READ,   8'h00,             11'd0,    1'b1, '{7'd2, 5'd0, 16'h0741, 1'b0}},
            '{OP_READ,   8'h00,             11'd1,    1'b1, '{7'd2, 5'd0, 16'h077F, 1'b0}},
            '{OP_PUT,    CH_HT,             11'd0,    1'b1, '{7'd8, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    CH_BS,             11'd0,    1'b1, '{7'd7, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    CH_CR,             11'd0,    1'b1, '{7'd0, 5'd0, 16'h0000, 1'b0}},
            '{OP_PUT,    CH_LF,             11'd0,    1'b1, '{7'd0, 5'd1, 16'h0000, 1'b0}},
            '{OP_PUT,    CH_SPACE,          11'h555,  1'b0, '0},
            '{OP_PUT,    CH_HT,             11'h2AA,  1'b0, '0},
            '{OP_READ,   8'h00,             11'd80,   1'b0, '0},
            '{OP_CLEAR,  8'hAA,             11'd5,    1'b1, '{7'd0, 5'd0, 16'h0000, 1'b0}},
            '{OP_READ,   8'h00,             11'd0,    1'b1, '{7'd0, 5'd0, 16'h0720, 1'b0}},
            '{OP_PUT,    8'h7E,             11'd0,    1'b0, '0},
            '{OP_READ,   8'h00,             11'd0,    1'b0, '0}
        };

        // reset once; the engine then runs its clearing pass with ready low
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase one: sender idle chance 28 percent, receiver stall chance 45 percent
        send_idle_pct = 28;
        recv_idle_pct = 45;
        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].ch, directed_rows[r].idx,
                         directed_rows[r].typed, directed_rows[r].answer);
        settle();
        set_colors(4'hF, 4'h0, 1'b1);
        run_random_phase(100);

        // phase two: idling the other way round, colors at the other extreme
        settle();
        send_idle_pct = 45;
        recv_idle_pct = 28;
        set_colors(4'h0, 4'hF, 1'b0);
        run_random_phase(100);

        // phase three: no idling, random colors
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_colors(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)), 1'b1);
        run_random_phase(100);

        settle();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
